// ===== src/multichannel_sar_offset_calibration_unit_defines.svh =====
// Assertion macros for the calibration unit checker.
`ifndef MULTICHANNEL_SAR_OFFSET_CALIBRATION_UNIT_DEFINES_SVH
`define MULTICHANNEL_SAR_OFFSET_CALIBRATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MSOC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define MSOC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/msoc_pkg.sv =====
// Shared types and constants of the SAR offset calibration unit.
package msoc_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 64;

   localparam int CODE_W  = 5;
   localparam int CH_W    = 6;
   localparam int ROW_W   = 4;
   localparam int RAW_W   = 32;
   localparam int FUNC_W  = 2;
   localparam int BITS_W  = 3;
   localparam int CNT7_W  = 7;
   localparam int ROWS_W  = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   localparam logic [BITS_W-1:0] CODE_BITS_RESET     = 3'd4;
   localparam logic [CNT7_W-1:0] CHANNEL_COUNT_RESET = 7'd64;
   localparam logic [RAW_W-1:0]  THRESHOLD_RESET     = 32'd2048;
   localparam logic [ROWS_W-1:0] ROWS_SEARCHED_RESET = 5'd1;
   localparam logic [BITS_W-1:0] CODE_BITS_MAX       = 3'd5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START  = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_FRAME  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CODE_BITS     = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1,
      CSR_THRESHOLD     = 2'd2,
      CSR_ROWS_SEARCHED = 2'd3
   } csr_index_type;

   // Control handed to the code update unit for one channel
   typedef struct packed {
      logic              is_start;
      logic              active;
      logic              hit;
      logic [CODE_W-1:0] trial;
   } step_ctl_type;

endpackage

// ===== src/multichannel_sar_offset_calibration_unit.sv =====
// Top level of the multichannel SAR offset calibration unit.
//
//  channel | ports              | payload (low bit first)
//  --------+--------------------+------------------------------------------
//  req     | req_t{valid,ready} | tuser: func; tdata: channel, row, raw
//  rsp     | rsp_t{valid,ready} | tuser: final_res; tdata: out_channel, code;
//          |                    | tlast: last
//  csr     | csr_{valid,ready}  | csr_index, csr_data
//
// Samples are absorbed in ST_IDLE and leave req_tready high.
// Start sweeps every code entry: active channels pass ST_RD, ST_UPD, ST_OUT,
// inactive ones ST_RD, ST_UPD. End of frame sweeps only the active channels. A
// sweep runs through the single code RAM read port and the update unit, one
// channel at a time; req_tready stays low until it ends; rsp stalls hold it.
// Reset is synchronous, active high; the code RAM needs no clearing.
module multichannel_sar_offset_calibration_unit
   import msoc_pkg::*;
#(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // channel[5:0], row[9:6], raw[41:10]
   input  logic [FUNC_W-1:0]     req_tuser,   // func[1:0]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_channel[5:0], code[10:6]
   output logic                  rsp_tuser,   // final_res
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data
);

   localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RD   = 4'b0010,
      ST_UPD  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [BITS_W-1:0] code_bits_ff;
   logic [CNT7_W-1:0] channel_count_ff;
   logic [RAW_W-1:0]  threshold_ff;
   logic [ROWS_W-1:0] rows_searched_ff;

   // search state
   logic [CODE_W-1:0]       trial_bit_ff, trial_bit_in;
   logic                    searching_ff, searching_in;
   logic [MAX_CHANNELS-1:0] hit_ff, hit_in;

   // sweep control, latched per transaction
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              op_start_ff, op_start_in;
   logic              op_final_ff, op_final_in;
   logic [CODE_W-1:0] op_trial_ff, op_trial_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]   rsp_chan_ff, rsp_chan_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic              rsp_final_ff, rsp_final_in;
   logic              rsp_last_ff, rsp_last_in;

   // input fields
   func_type          req_func;
   logic [CH_W-1:0]   req_channel;
   logic [ROW_W-1:0]  req_row;
   logic [RAW_W-1:0]  req_raw;

   logic              req_fire;
   logic [CNT_W-1:0]  n_eff;
   logic [BITS_W-1:0] bits_eff;
   logic [CODE_W-1:0] start_trial;
   logic [CODE_W-1:0] frame_next;
   logic              sample_hit;
   logic              chan_active;
   logic              chan_done;
   logic [CNT_W-1:0]  sweep_limit;

   step_ctl_type      step_ctl;
   logic [CODE_W-1:0] ram_rd_data;
   logic [CODE_W-1:0] step_code;
   logic              ram_wr_en;

   assign req_func    = func_type'(req_tuser);
   assign req_channel = req_tdata[CH_W-1:0];
   assign req_row     = req_tdata[CH_W +: ROW_W];
   assign req_raw     = req_tdata[CH_W+ROW_W +: RAW_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Effective channel count and code width under the current registers
   always_comb begin
      if (channel_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (channel_count_ff > CNT7_W'(MAX_CHANNELS)) begin
         n_eff = CNT_W'(MAX_CHANNELS);
      end else begin
         n_eff = CNT_W'(channel_count_ff);
      end

      if (code_bits_ff == '0) begin
         bits_eff = BITS_W'(1);
      end else if (code_bits_ff > CODE_BITS_MAX) begin
         bits_eff = CODE_BITS_MAX;
      end else begin
         bits_eff = code_bits_ff;
      end
   end

   assign start_trial = CODE_W'(1) << (bits_eff - BITS_W'(1));
   assign frame_next  = trial_bit_ff >> 1;

   assign sample_hit = searching_ff
                    && (CNT_W'(req_channel) < n_eff)
                    && ({1'b0, req_row} < rows_searched_ff)
                    && (req_raw <= threshold_ff);

   // Start walks the whole store so stale codes above the count become zero
   assign sweep_limit = op_start_ff ? CNT_W'(MAX_CHANNELS) : n_ff;
   assign chan_active = (cnt_ff < n_ff);
   assign chan_done   = (cnt_ff == (sweep_limit - CNT_W'(1)));

   assign step_ctl.is_start = op_start_ff;
   assign step_ctl.active   = chan_active;
   assign step_ctl.hit      = hit_ff[cnt_ff[ADDR_W-1:0]];
   assign step_ctl.trial    = op_trial_ff;

   assign ram_wr_en = (state_ff == ST_UPD);

   msoc_code_ram #(
      .DEPTH  (MAX_CHANNELS),
      .ADDR_W (ADDR_W)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (step_code),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   msoc_step_unit u_step (
      .ctl      (step_ctl),
      .code_in  (ram_rd_data),
      .code_out (step_code)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      trial_bit_in = trial_bit_ff;
      searching_in = searching_ff;
      hit_in       = hit_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      op_start_in  = op_start_ff;
      op_final_in  = op_final_ff;
      op_trial_in  = op_trial_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_final_in = rsp_final_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_func)
                  FUNC_START: begin
                     trial_bit_in = start_trial;
                     searching_in = 1'b1;
                     hit_in       = '0;
                     cnt_in       = '0;
                     n_in         = n_eff;
                     op_start_in  = 1'b1;
                     op_final_in  = 1'b0;
                     op_trial_in  = start_trial;
                     state_in     = ST_RD;
                  end
                  FUNC_SAMPLE: begin
                     if (sample_hit) begin
                        hit_in[req_channel[ADDR_W-1:0]] = 1'b1;
                     end
                  end
                  FUNC_FRAME: begin
                     if (searching_ff) begin
                        trial_bit_in = frame_next;
                        searching_in = (frame_next != '0);
                        cnt_in       = '0;
                        n_in         = n_eff;
                        op_start_in  = 1'b0;
                        op_final_in  = (frame_next == '0);
                        op_trial_in  = trial_bit_ff;
                        state_in     = ST_RD;
                     end
                  end
                  FUNC_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD: begin
            // RAM read data lands at the end of this cycle
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (chan_active) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = CH_W'(cnt_ff);
               rsp_code_in  = step_code;
               rsp_final_in = op_final_ff;
               rsp_last_in  = (cnt_ff == (n_ff - CNT_W'(1)));
               state_in     = ST_OUT;
            end else if (chan_done) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_RD;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (chan_done) begin
                  if (!op_start_ff) begin
                     hit_in = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         code_bits_ff     <= CODE_BITS_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
         threshold_ff     <= THRESHOLD_RESET;
         rows_searched_ff <= ROWS_SEARCHED_RESET;
         trial_bit_ff     <= '0;
         searching_ff     <= 1'b0;
         hit_ff           <= '0;
         cnt_ff           <= '0;
         op_start_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         trial_bit_ff <= trial_bit_in;
         searching_ff <= searching_in;
         hit_ff       <= hit_in;
         cnt_ff       <= cnt_in;
         op_start_ff  <= op_start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_CODE_BITS:     code_bits_ff     <= csr_data[BITS_W-1:0];
               CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[CNT7_W-1:0];
               CSR_THRESHOLD:     threshold_ff     <= csr_data[RAW_W-1:0];
               CSR_ROWS_SEARCHED: rows_searched_ff <= csr_data[ROWS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      op_final_ff  <= op_final_in;
      op_trial_ff  <= op_trial_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_final_ff <= rsp_final_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CH_W-CODE_W){1'b0}}, rsp_code_ff, rsp_chan_ff};
   assign rsp_tuser  = rsp_final_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/msoc_code_ram.sv =====
// Per-channel code store, one write and one registered read port.
module msoc_code_ram
   import msoc_pkg::*;
#(
   parameter int DEPTH  = MAX_CHANNELS_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CODE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CODE_W-1:0] rd_data
);

   logic [CODE_W-1:0] mem [DEPTH];
   logic [CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/msoc_step_unit.sv =====
// Shared code update unit: start seeding and trial-bit decision per channel.
module msoc_step_unit
   import msoc_pkg::*;
(
   input  step_ctl_type      ctl,
   input  logic [CODE_W-1:0] code_in,
   output logic [CODE_W-1:0] code_out
);

   logic [CODE_W-1:0] kept;
   logic [CODE_W-1:0] next_trial;

   always_comb begin
      next_trial = ctl.trial >> 1;
      kept       = ctl.hit ? (code_in & ~ctl.trial) : code_in;
      if (ctl.is_start) begin
         code_out = ctl.active ? ctl.trial : '0;
      end else begin
         // next_trial is zero after the lowest bit, leaving the final code
         code_out = kept | next_trial;
      end
   end

endmodule

// ===== src/msoc_checker.sv =====
// Port-level checker for the calibration unit, bound to the top level.
`include "multichannel_sar_offset_calibration_unit_defines.svh"

module msoc_checker
   import msoc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [FUNC_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // a result waiting on the output holds its payload
   `MSOC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "rsp payload changed while stalled")

   // no new transaction is taken while a sweep is emitting
   `MSOC_ASSERT_IMPLY(a_busy_emit, clock, reset, rsp_tvalid, !req_tready, "req_tready high during result output")

   // a start always launches a sweep
   `MSOC_ASSERT_NEXT(a_start_busy, clock, reset, req_tvalid && req_tready && (req_tuser == FUNC_START), !req_tready, "start did not begin a sweep")

   // samples are absorbed without stalling the input
   `MSOC_ASSERT_NEXT(a_sample_fast, clock, reset, req_tvalid && req_tready && (req_tuser == FUNC_SAMPLE), req_tready && !rsp_tvalid, "sample stalled the input")

endmodule

bind multichannel_sar_offset_calibration_unit msoc_checker u_msoc_checker (.*);

// ===== tb/multichannel_sar_offset_calibration_unit_test.sv =====
// Self-checking testbench for the multichannel SAR offset calibration unit.
module multichannel_sar_offset_calibration_unit_test
   import msoc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES   = 220;   // start sweep may run on over idle entries
   localparam int TAIL_CYCLES     = 300;
   localparam int RSP_HOLD_CYCLES = 400;   // long receiver stall, fills the block
   localparam int RANDOM_ITEMS    = 500;
   localparam int CALM_AFTER      = 440;   // no idling from here to the end
   localparam int MAX_PRINTS      = 40;
   localparam int PLAN_ROWS       = 34;

   // One code report as it leaves the block
   typedef struct packed {
      logic [CH_W-1:0]   chan;
      logic [CODE_W-1:0] code;
      logic              fin;
      logic              last;
   } code_report_type;

   // Directed row: either a register write or one input transaction. Rows with
   // pinned set carry the code and final flag that every report must show.
   typedef struct packed {
      logic                  is_csr;
      csr_index_type         idx;
      logic [CSR_DAT_W-1:0]  wdata;
      func_type              func;
      logic [CH_W-1:0]       chan;
      logic [ROW_W-1:0]      row;
      logic [RAW_W-1:0]      raw;
      logic                  pinned;
      logic [CODE_W-1:0]     pin_code;
      logic                  pin_final;
   } plan_row_type;

   localparam plan_row_type PLAN [0:PLAN_ROWS-1] = '{
      // idle block: frame end, sample and the unused code are all dropped
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_FRAME,  6'd0,  4'd0,  32'd0,  1'b0, 5'd0,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd0,  4'd0,  32'd0,  1'b0, 5'd0,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_NONE,   6'd63, 4'd15, '1,     1'b0, 5'd0,  1'b0},
      // reset settings: 4 bits, 64 channels, every code starts at 8
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_START,  6'd0,  4'd0,  32'd0,  1'b1, 5'd8,  1'b0},
      // double hit on channel 0 (second at exactly threshold), miss just above
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd0,  4'd0,  32'd0,  1'b0, 5'd0,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd0,  4'd0,  32'd2048, 1'b0, 5'd0, 1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd63, 4'd0,  32'd2049, 1'b0, 5'd0, 1'b0},
      // row past rows_searched is dropped
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd5,  4'd1,  32'd0,  1'b0, 5'd0,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_FRAME,  6'd0,  4'd0,  32'd0,  1'b0, 5'd0,  1'b0},
      // restart in the middle of a search
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_START,  6'd0,  4'd0,  32'd0,  1'b1, 5'd8,  1'b0},
      // one bit, one channel, widest threshold and rows
      '{1'b1, CSR_CODE_BITS,     32'd1,        FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b1, CSR_CHANNEL_COUNT, 32'd1,        FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b1, CSR_THRESHOLD,     32'hFFFFFFFF, FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b1, CSR_ROWS_SEARCHED, 32'd16,       FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_START,  6'd0,  4'd0,  32'd0,  1'b1, 5'd1,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd0,  4'd15, '1,     1'b0, 5'd0,  1'b0},
      // channel past the active count is dropped
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd1,  4'd15, '1,     1'b0, 5'd0,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_FRAME,  6'd0,  4'd0,  32'd0,  1'b1, 5'd0,  1'b1},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_FRAME,  6'd0,  4'd0,  32'd0,  1'b0, 5'd0,  1'b0},
      // zero code width and zero count act as one; zero rows checks nothing
      '{1'b1, CSR_CODE_BITS,     32'd0, FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b1, CSR_CHANNEL_COUNT, 32'd0, FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b1, CSR_THRESHOLD,     32'd0, FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b1, CSR_ROWS_SEARCHED, 32'd0, FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_START,  6'd0,  4'd0,  32'd0,  1'b1, 5'd1,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd0,  4'd0,  32'd0,  1'b0, 5'd0,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_FRAME,  6'd0,  4'd0,  32'd0,  1'b1, 5'd1,  1'b1},
      // oversized width and count clamp to 5 bits and 64 channels
      '{1'b1, CSR_CODE_BITS,     32'd7,   FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b1, CSR_CHANNEL_COUNT, 32'd127, FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b1, CSR_ROWS_SEARCHED, 32'd31,  FUNC_NONE, 6'd0, 4'd0, 32'd0, 1'b0, 5'd0, 1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_START,  6'd0,  4'd0,  32'd0,  1'b1, 5'd16, 1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd63, 4'd15, 32'd0,  1'b0, 5'd0,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_SAMPLE, 6'd42, 4'd9,  32'd0,  1'b0, 5'd0,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_FRAME,  6'd0,  4'd0,  32'd0,  1'b0, 5'd0,  1'b0},
      '{1'b0, CSR_CODE_BITS, 32'd0, FUNC_FRAME,  6'd0,  4'd0,  32'd0,  1'b0, 5'd0,  1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // channel[5:0], row[9:6], raw[41:10]
   logic [FUNC_W-1:0]     req_tuser;   // func[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // out_channel[5:0], code[10:6]
   logic                  rsp_tuser;   // final_res
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_data;

   multichannel_sar_offset_calibration_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the block: register copies, code table, hit flags, search
   // ---------------------------------------------------------------------
   logic [BITS_W-1:0] cfg_code_bits;
   logic [CNT7_W-1:0] cfg_chan_count;
   logic [RAW_W-1:0]  cfg_threshold;
   logic [ROWS_W-1:0] cfg_rows;
   logic [CODE_W-1:0] cal_code [MAX_CHANNELS_DEFAULT];
   bit                cal_hit  [MAX_CHANNELS_DEFAULT];
   logic [CODE_W-1:0] cal_trial;
   bit                cal_running;

   code_report_type pending_reports [$];

   // Pinned values for the transaction being offered (directed rows only)
   bit                pin_on;
   logic [CODE_W-1:0] pin_code;
   bit                pin_final;

   // Stimulus control shared with the receiver process
   bit calm;
   bit hold_rsp;
   int req_idle_pct;
   int rsp_idle_pct;
   bit items_since_csr;

   int mismatch_count;
   int items_sent;
   int real_items;
   int reports_checked;
   int searches_started;
   int csr_writes;

   // Count in force after clamping to 1 .. MAX_CHANNELS
   function automatic int unsigned live_channels();
      if (cfg_chan_count == 0) return 1;
      if (cfg_chan_count > MAX_CHANNELS_DEFAULT) return MAX_CHANNELS_DEFAULT;
      return cfg_chan_count;
   endfunction

   // Number of trial steps after clamping to 1 .. 5
   function automatic int unsigned trial_steps();
      if (cfg_code_bits == 0) return 1;
      if (cfg_code_bits > CODE_BITS_MAX) return CODE_BITS_MAX;
      return cfg_code_bits;
   endfunction

   // One report per live channel, channel 0 first, last flag on the final one
   function automatic void queue_code_run(input bit fin);
      int unsigned     n;
      code_report_type r;
      n = live_channels();
      for (int unsigned c = 0; c < n; c++) begin
         r.chan = CH_W'(c);
         r.code = pin_on ? pin_code : cal_code[c];
         r.fin  = pin_on ? pin_final : fin;
         r.last = (c + 1 == n);
         pending_reports.push_back(r);
      end
   endfunction

   function automatic void advance_search(input func_type f, input logic [CH_W-1:0] ch,
                                          input logic [ROW_W-1:0] rw, input logic [RAW_W-1:0] rv);
      int unsigned n;
      n = live_channels();
      case (f)
         FUNC_START: begin
            cal_trial = CODE_W'(1 << (trial_steps() - 1));
            for (int c = 0; c < MAX_CHANNELS_DEFAULT; c++) begin
               cal_code[c] = (c < n) ? cal_trial : '0;
               cal_hit[c]  = 1'b0;
            end
            cal_running = 1'b1;
            searches_started++;
            queue_code_run(1'b0);
         end
         FUNC_SAMPLE: begin
            if (cal_running && ch < n && rw < cfg_rows && rv <= cfg_threshold)
               cal_hit[ch] = 1'b1;
         end
         FUNC_FRAME: begin
            if (cal_running) begin
               for (int unsigned c = 0; c < n; c++)
                  if (cal_hit[c]) cal_code[c] &= ~cal_trial;
               for (int c = 0; c < MAX_CHANNELS_DEFAULT; c++)
                  cal_hit[c] = 1'b0;
               cal_trial >>= 1;
               if (cal_trial == 0) begin
                  cal_running = 1'b0;
                  queue_code_run(1'b1);
               end else begin
                  for (int unsigned c = 0; c < n; c++)
                     cal_code[c] |= cal_trial;
                  queue_code_run(1'b0);
               end
            end
         end
         default: ;   // unused code, dropped
      endcase
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Monitor: every handshake seen at the rising edge, in one process so that
   // register writes, predictions and checks keep a fixed order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      code_report_type got;
      code_report_type want;
      if (reset) begin
         cfg_code_bits  = CODE_BITS_RESET;
         cfg_chan_count = CHANNEL_COUNT_RESET;
         cfg_threshold  = THRESHOLD_RESET;
         cfg_rows       = ROWS_SEARCHED_RESET;
         for (int c = 0; c < MAX_CHANNELS_DEFAULT; c++) begin
            cal_code[c] = '0;
            cal_hit[c]  = 1'b0;
         end
         cal_trial   = '0;
         cal_running = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.chan = rsp_tdata[CH_W-1:0];
            got.code = rsp_tdata[CH_W +: CODE_W];
            got.fin  = rsp_tuser;
            got.last = rsp_tlast;
            reports_checked++;
            if (pending_reports.size() == 0) begin
               flag_mismatch($sformatf("report ch %0d code %0d with nothing expected",
                                       got.chan, got.code));
            end else begin
               want = pending_reports.pop_front();
               if (got.chan !== want.chan)
                  flag_mismatch($sformatf("channel %0d, expected %0d", got.chan, want.chan));
               if (got.code !== want.code)
                  flag_mismatch($sformatf("ch %0d code %0d, expected %0d",
                                          want.chan, got.code, want.code));
               if (got.fin !== want.fin)
                  flag_mismatch($sformatf("ch %0d final %b, expected %b",
                                          want.chan, got.fin, want.fin));
               if (got.last !== want.last)
                  flag_mismatch($sformatf("ch %0d last %b, expected %b",
                                          want.chan, got.last, want.last));
            end
         end
         if (req_tvalid && req_tready)
            advance_search(func_type'(req_tuser), req_tdata[CH_W-1:0],
                           req_tdata[CH_W +: ROW_W], req_tdata[CH_W+ROW_W +: RAW_W]);
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_CODE_BITS:     cfg_code_bits  = csr_data[BITS_W-1:0];
               CSR_CHANNEL_COUNT: cfg_chan_count = csr_data[CNT7_W-1:0];
               CSR_THRESHOLD:     cfg_threshold  = csr_data[RAW_W-1:0];
               CSR_ROWS_SEARCHED: cfg_rows       = csr_data[ROWS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      int burst;
      int held;
      rsp_tready = 1'b0;
      burst      = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            for (held = 0; held < RSP_HOLD_CYCLES; held++)
               @(negedge clock);
            hold_rsp = 1'b0;
         end
         if (burst > 0) begin
            burst--;
            rsp_tready = 1'b0;
         end else if (!calm && $urandom_range(0, 99) < rsp_idle_pct) begin
            burst      = $urandom_range(1, 8) - 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender side. Tasks are entered just after a falling edge and return
   // just after one; valid stays high across back-to-back transactions.
   // ---------------------------------------------------------------------
   task automatic send_item(input func_type f, input logic [CH_W-1:0] ch,
                            input logic [ROW_W-1:0] rw, input logic [RAW_W-1:0] rv,
                            input bit pinned = 1'b0, input logic [CODE_W-1:0] pcode = '0,
                            input bit pfinal = 1'b0);
      int gap;
      if (!calm && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
      end
      req_tuser  = f;
      req_tdata  = {6'b0, rv, rw, ch};
      pin_on     = pinned;
      pin_code   = pcode;
      pin_final  = pfinal;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
      items_since_csr = 1'b1;
   endtask

   task automatic wait_for_reports();
      req_tvalid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   // Registers change only with the block idle: all reports back, and any
   // trailing sweep over inactive entries given time to finish.
   task automatic write_register(input csr_index_type idx, input logic [CSR_DAT_W-1:0] value);
      wait_for_reports();
      if (items_since_csr) begin
         repeat (SETTLE_CYCLES) @(negedge clock);
         items_since_csr = 1'b0;
      end
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      csr_writes++;
   endtask

   task automatic retune_registers();
      int pick;
      logic [CSR_DAT_W-1:0] value;
      if ($urandom_range(0, 1)) write_register(CSR_CODE_BITS, $urandom_range(0, 7));
      if ($urandom_range(0, 1)) begin
         // mostly a handful of channels, now and then wide or out of range
         pick = $urandom_range(0, 9);
         if (pick < 7)      value = $urandom_range(1, 8);
         else if (pick < 9) value = $urandom_range(9, 64);
         else               value = $urandom_range(0, 127);
         write_register(CSR_CHANNEL_COUNT, value);
      end
      if ($urandom_range(0, 1)) begin
         pick = $urandom_range(0, 9);
         if (pick < 4)       value = $urandom();
         else if (pick < 8)  value = $urandom_range(0, 4095);
         else if (pick == 8) value = '0;
         else                value = '1;
         write_register(CSR_THRESHOLD, value);
      end
      if ($urandom_range(0, 1)) write_register(CSR_ROWS_SEARCHED, $urandom_range(0, 31));
   endtask

   // Sample aimed mostly at live channels and rows, raw close to threshold
   task automatic send_sample(input int unsigned n);
      logic [CH_W-1:0]  ch;
      logic [ROW_W-1:0] rw;
      logic [RAW_W-1:0] rv;
      logic [RAW_W-1:0] offset;
      int pick;
      if ($urandom_range(0, 9) == 0) ch = CH_W'($urandom_range(0, 63));
      else                           ch = CH_W'($urandom_range(0, n - 1));
      if (cfg_rows == 0 || $urandom_range(0, 6) == 0)
         rw = ROW_W'($urandom_range(0, 15));
      else
         rw = ROW_W'($urandom_range(0, (cfg_rows > 16) ? 15 : cfg_rows - 1));
      offset = $urandom_range(0, 64);
      pick   = $urandom_range(0, 9);
      if (pick < 4)      rv = (cfg_threshold >= offset) ? cfg_threshold - offset : '0;
      else if (pick < 8) rv = cfg_threshold + offset;
      else               rv = $urandom();
      if (ch < n && rw < cfg_rows) real_items++;
      send_item(FUNC_SAMPLE, ch, rw, rv);
   endtask

   task automatic send_noise();
      send_item(func_type'($urandom_range(1, 3)), CH_W'($urandom()), ROW_W'($urandom()),
                $urandom());
   endtask

   // One search from start to final codes; sometimes broken off or salted
   // with stray transactions. squeeze: 64 channels behind a stalled receiver.
   task automatic run_campaign(input bit squeeze);
      int unsigned n;
      int unsigned steps;
      int nsamp;
      req_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
      rsp_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
      if (squeeze) begin
         write_register(CSR_CHANNEL_COUNT, 32'd64);
         write_register(CSR_CODE_BITS, 32'd2);
         hold_rsp = 1'b1;
      end else if ($urandom_range(0, 99) < 35) begin
         retune_registers();
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      send_item(FUNC_START, CH_W'($urandom()), ROW_W'($urandom()), $urandom());
      real_items++;
      n     = live_channels();
      steps = trial_steps();
      for (int unsigned s = 0; s < steps; s++) begin
         nsamp = $urandom_range(0, (n < 8) ? 2 * n : 16);
         for (int k = 0; k < nsamp; k++) begin
            send_sample(n);
            if ($urandom_range(0, 29) == 0) send_noise();
         end
         if ($urandom_range(0, 39) == 0) return;   // abandon, next start restarts
         send_item(FUNC_FRAME, CH_W'($urandom()), ROW_W'($urandom()), $urandom());
         real_items++;
      end
      // the sender also waits out the whole result stream now and then
      if ($urandom_range(0, 4) == 0) wait_for_reports();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int campaign;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_START;
      csr_valid  = 1'b0;
      csr_index  = CSR_CODE_BITS;
      csr_data   = '0;
      pin_on     = 1'b0;
      pin_code   = '0;
      pin_final  = 1'b0;
      calm       = 1'b0;
      hold_rsp   = 1'b0;
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      items_since_csr = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (PLAN[i].is_csr)
            write_register(PLAN[i].idx, PLAN[i].wdata);
         else
            send_item(PLAN[i].func, PLAN[i].chan, PLAN[i].row, PLAN[i].raw,
                      PLAN[i].pinned, PLAN[i].pin_code, PLAN[i].pin_final);
      end
      write_register(CSR_CHANNEL_COUNT, 32'd8);

      // random searches; campaign 1 runs with the receiver held off
      campaign = 0;
      while (real_items < RANDOM_ITEMS) begin
         if (real_items >= CALM_AFTER) calm = 1'b1;
         run_campaign(campaign == 1);
         campaign++;
      end

      wait_for_reports();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Run covered %0d transactions over %0d searches and %0d register writes,",
               items_sent, searches_started, csr_writes);
      $display("with %0d code reports compared and %0d mismatches.",
               reports_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #20_000_000;
      $display("Timed out with %0d reports still expected.", pending_reports.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
